FILE: rtl/core/mpd_pkg.sv
// Shared types and constants for the multiprecision divider.
// Holds the command codes, the transaction payload structs and the core status struct.
// No dependencies.
`default_nettype none

package mpd_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 4;
  localparam int LIMB_W = 31;

  localparam logic [CMD_W-1:0] CMD_LOAD_DIVIDEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_DIVISOR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DIVIDE        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_QUOTIENT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_REMAINDER = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  limb_index;
    logic [LIMB_W-1:0] limb_value;
  } mpd_cmd_t;

  typedef struct packed {
    logic [LIMB_W-1:0] limb_out;
    logic              divide_by_zero;
  } mpd_res_t;

  typedef struct packed {
    logic done;
    logic by_zero;
  } mpd_div_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mpd_div_core.sv
// Restoring division core: one shared subtractor, one quotient bit per cycle.
// Depends on mpd_pkg for the status struct.
`default_nettype none

module mpd_div_core #(
  parameter int LIMBS     = 16,
  parameter int LIMB_BITS = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [LIMBS*LIMB_BITS-1:0]     dividend,
  input  wire logic [LIMBS*LIMB_BITS-1:0]     divisor,
  output mpd_pkg::mpd_div_status_t            status,
  output logic      [LIMBS*LIMB_BITS-1:0]     quotient,
  output logic      [LIMBS*LIMB_BITS-1:0]     remainder
);
  import mpd_pkg::*;

  localparam int N_BITS = LIMBS * LIMB_BITS;
  localparam int CNT_W  = $clog2(N_BITS + 1);

  logic              busy;
  logic              done;
  logic              by_zero;
  logic [CNT_W-1:0]  cnt;
  logic [N_BITS-1:0] rem;
  logic [N_BITS-1:0] quo;

  logic              div_zero;
  logic [N_BITS:0]   shifted;
  logic [N_BITS+1:0] diff;
  logic              ge;
  logic [N_BITS-1:0] rem_next;
  logic [N_BITS-1:0] quo_next;

  assign div_zero = (divisor == '0);

  // Bring down the next dividend bit, then trial-subtract the divisor.
  assign shifted  = {rem, quo[N_BITS-1]};
  assign diff     = {1'b0, shifted} - {2'b00, divisor};
  assign ge       = ~diff[N_BITS+1];
  assign rem_next = ge ? diff[N_BITS-1:0] : shifted[N_BITS-1:0];
  assign quo_next = {quo[N_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      by_zero <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        by_zero <= div_zero;
        if (div_zero) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(N_BITS);
        end
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= div_zero ? '1 : dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign status.done    = done;
  assign status.by_zero = by_zero;
  assign quotient       = quo;
  assign remainder      = rem;

endmodule

`default_nettype wire

FILE: rtl/core/multiprecision_divider_unit.sv
// Multiprecision divider: loads, a divide and reads of LIMBS limbs of LIMB_BITS each.
// Load: taken with no result. Read: result registered the cycle after the transaction.
// Divide: a zero divisor skips the subtract loop and sets the divide_by_zero flag;
// one quotient bit per cycle through the shared subtractor in mpd_div_core; no new command
// is taken until the divide result is out. Reset (rst, synchronous) clears all limb stores,
// the zero-divisor flag and the result valid. Depends on mpd_pkg and mpd_div_core.
`default_nettype none

module multiprecision_divider_unit #(
  parameter int LIMBS     = 16,
  parameter int LIMB_BITS = 31
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire mpd_pkg::mpd_cmd_t cmd,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output mpd_pkg::mpd_res_t      res
);
  import mpd_pkg::*;

  localparam int N_BITS = LIMBS * LIMB_BITS;
  localparam int IW     = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state;

  logic [LIMBS-1:0][LIMB_BITS-1:0] dividend_limbs;
  logic [LIMBS-1:0][LIMB_BITS-1:0] divisor_limbs;
  logic [LIMBS-1:0][LIMB_BITS-1:0] quotient_limbs;
  logic [LIMBS-1:0][LIMB_BITS-1:0] remainder_limbs;
  logic                            zero_divisor_flag;

  logic                 accept;
  logic                 idx_ok;
  logic [IW-1:0]        idx;
  logic [LIMB_BITS-1:0] load_value;
  logic                 is_read;
  logic [LIMB_W-1:0]    read_value;
  logic                 div_start;
  logic                 div_finish;

  mpd_div_status_t      status;
  logic [N_BITS-1:0]    q_flat;
  logic [N_BITS-1:0]    r_flat;

  assign cmd_ready  = (state == ST_IDLE) && (!res_valid || res_ready);
  assign accept     = cmd_valid && cmd_ready;
  assign idx_ok     = {28'd0, cmd.limb_index} < LIMBS;
  assign idx        = IW'(cmd.limb_index);
  assign load_value = LIMB_BITS'(cmd.limb_value);
  assign is_read    = (cmd.command == CMD_READ_QUOTIENT) || (cmd.command == CMD_READ_REMAINDER);
  assign div_start  = accept && (cmd.command == CMD_DIVIDE);
  assign div_finish = (state == ST_DIV) && status.done;

  always_comb begin
    read_value = '0;
    if (idx_ok) begin
      case (cmd.command)
        CMD_READ_QUOTIENT:  read_value = LIMB_W'(quotient_limbs[idx]);
        CMD_READ_REMAINDER: read_value = LIMB_W'(remainder_limbs[idx]);
        default:            read_value = '0;
      endcase
    end
  end

  mpd_div_core #(
    .LIMBS     (LIMBS),
    .LIMB_BITS (LIMB_BITS)
  ) u_div_core (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend_limbs),
    .divisor   (divisor_limbs),
    .status    (status),
    .quotient  (q_flat),
    .remainder (r_flat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (div_start) state <= ST_DIV;
        ST_DIV:  if (status.done) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dividend_limbs    <= '0;
      divisor_limbs     <= '0;
      quotient_limbs    <= '0;
      remainder_limbs   <= '0;
      zero_divisor_flag <= 1'b0;
    end else begin
      if (accept && idx_ok && (cmd.command == CMD_LOAD_DIVIDEND)) begin
        dividend_limbs[idx] <= load_value;
      end
      if (accept && idx_ok && (cmd.command == CMD_LOAD_DIVISOR)) begin
        divisor_limbs[idx] <= load_value;
      end
      if (div_finish) begin
        quotient_limbs    <= q_flat;
        remainder_limbs   <= r_flat;
        zero_divisor_flag <= status.by_zero;
      end
    end
  end

  // Output register: a new result takes priority over draining the old one.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (div_finish || (accept && is_read)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_finish) begin
      res.limb_out       <= '0;
      res.divide_by_zero <= status.by_zero;
    end else if (accept && is_read) begin
      res.limb_out       <= read_value;
      res.divide_by_zero <= zero_divisor_flag;
    end
  end

`ifndef SYNTH
  a_busy_not_ready : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !cmd_ready)
    else $error("command taken while a divide is running");

  a_divide_enters : assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_DIV))
    else $error("divide transaction did not start the sequencer");

  a_done_in_div : assert property (@(posedge clk) disable iff (rst)
    status.done |-> (state == ST_DIV))
    else $error("core finished outside a divide");

  a_divide_result : assert property (@(posedge clk) disable iff (rst)
    div_finish |=> (res_valid && (res.limb_out == '0) && (res.divide_by_zero == zero_divisor_flag)))
    else $error("divide result not presented correctly");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_multiprecision_divider_unit.sv
// Self-checking bench for multiprecision_divider_unit: directed and random loads, divides, reads.
// A behavioural divider tracks the limb stores and checks every result transaction in order.
// Depends on mpd_pkg and the divider RTL.
module tb_multiprecision_divider_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;

  localparam int LIMBS = 16;
  localparam int LW    = LIMB_W;
  localparam int WIDE  = LIMBS * LW;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  mpd_cmd_t cmd       = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  mpd_res_t res;

  mpd_cmd_t pending_cmds[$];
  mpd_res_t results_due[$];

  logic [LW-1:0] dividend_store[LIMBS];
  logic [LW-1:0] divisor_store[LIMBS];
  logic [LW-1:0] quotient_store[LIMBS];
  logic [LW-1:0] remainder_store[LIMBS];
  logic          zero_flag;

  logic cmd_taken = 1'b0;
  int   cmd_count = 0;
  int   mismatches = 0;
  int   items_queued = 0;

  multiprecision_divider_unit #(
    .LIMBS(LIMBS),
    .LIMB_BITS(LW)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #4 clk = ~clk;

  // Take a break with a chance of 29 in a hundred, except in a calm window of transactions.
  function automatic bit take_break();
    if (cmd_count >= 500 && cmd_count < 800) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  function automatic logic [LW-1:0] pick_limb();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return LW'($urandom_range(15));
      3: return LW'(1) << $urandom_range(LW - 1);
      default: return LW'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [LW-1:0] val);
    mpd_cmd_t c;
    c.command    = op;
    c.limb_index = idx;
    c.limb_value = val;
    pending_cmds.push_back(c);
    if (op <= CMD_READ_REMAINDER) items_queued++;
  endtask

  // Update the limb stores for one transaction and queue the result it owes.
  task automatic divider_step(input mpd_cmd_t c);
    logic [WIDE-1:0] num;
    logic [WIDE-1:0] den;
    logic [WIDE-1:0] quo;
    logic [WIDE-1:0] rem;
    mpd_res_t        r;
    r.limb_out = '0;
    case (c.command)
      CMD_LOAD_DIVIDEND: dividend_store[c.limb_index] = c.limb_value;
      CMD_LOAD_DIVISOR:  divisor_store[c.limb_index] = c.limb_value;
      CMD_DIVIDE: begin
        for (int i = 0; i < LIMBS; i++) begin
          num[i*LW +: LW] = dividend_store[i];
          den[i*LW +: LW] = divisor_store[i];
        end
        if (den == '0) begin
          quo       = '1;
          rem       = '0;
          zero_flag = 1'b1;
        end else begin
          quo       = num / den;
          rem       = num % den;
          zero_flag = 1'b0;
        end
        for (int i = 0; i < LIMBS; i++) begin
          quotient_store[i]  = quo[i*LW +: LW];
          remainder_store[i] = rem[i*LW +: LW];
        end
      end
      CMD_READ_QUOTIENT:  r.limb_out = quotient_store[c.limb_index];
      CMD_READ_REMAINDER: r.limb_out = remainder_store[c.limb_index];
      default: ;
    endcase
    r.divide_by_zero = zero_flag;
    if (c.command == CMD_DIVIDE || c.command == CMD_READ_QUOTIENT ||
        c.command == CMD_READ_REMAINDER)
      results_due.push_back(r);
  endtask

  // Look just after the falling edge, once the driver's updates have settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_cmds.size() != 0 || cmd_valid || results_due.size() != 0);
  endtask

  // Driver: present the next pending transaction once the last one is taken.
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (pending_cmds.size() != 0 && !take_break()) begin
        cmd       <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) res_ready <= 1'b0;
    else res_ready <= !take_break();
  end

  // Monitor: check results before predicting, so a result never meets its own command.
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
      zero_flag = 1'b0;
      for (int i = 0; i < LIMBS; i++) begin
        dividend_store[i]  = '0;
        divisor_store[i]   = '0;
        quotient_store[i]  = '0;
        remainder_store[i] = '0;
      end
    end else begin
      cmd_taken <= cmd_valid && cmd_ready;
      if (res_valid && res_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result limb_out=%h divide_by_zero=%b",
                     $realtime, res.limb_out, res.divide_by_zero);
        end else if (res.limb_out !== results_due[0].limb_out ||
                     res.divide_by_zero !== results_due[0].divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch limb_out exp %h got %h, divide_by_zero exp %b got %b",
                     $realtime, results_due[0].limb_out, res.limb_out,
                     results_due[0].divide_by_zero, res.divide_by_zero);
          void'(results_due.pop_front());
        end else begin
          void'(results_due.pop_front());
        end
      end
      if (cmd_valid && cmd_ready) begin
        divider_step(cmd);
        cmd_count++;
      end
    end
  end

  initial begin
    int dl;
    int vl;
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reads straight after reset, then a divide by the all-zero divisor.
    queue_item(CMD_READ_QUOTIENT, 4'd0, '0);
    queue_item(CMD_READ_REMAINDER, 4'd15, '1);
    queue_item(CMD_DIVIDE, 4'd0, '0);
    queue_item(CMD_READ_QUOTIENT, 4'd15, '0);
    queue_item(CMD_READ_REMAINDER, 4'd0, '0);
    // Extreme limbs: a divisor of one, then a divisor just under the dividend.
    queue_item(CMD_LOAD_DIVIDEND, 4'd15, '1);
    queue_item(CMD_LOAD_DIVIDEND, 4'd0, '1);
    queue_item(CMD_LOAD_DIVISOR, 4'd0, LW'(1));
    queue_item(CMD_DIVIDE, 4'd7, '1);
    queue_item(CMD_READ_QUOTIENT, 4'd15, '0);
    queue_item(CMD_READ_QUOTIENT, 4'd0, '0);
    queue_item(CMD_LOAD_DIVISOR, 4'd15, '1);
    queue_item(CMD_DIVIDE, 4'd0, '0);
    queue_item(CMD_READ_QUOTIENT, 4'd0, '0);
    queue_item(CMD_READ_REMAINDER, 4'd0, '0);
    queue_item(CMD_READ_REMAINDER, 4'd15, '0);
    // Unused command codes take a transaction and return nothing.
    queue_item(3'd5, 4'd15, '1);
    queue_item(3'd6, 4'd0, '0);
    queue_item(3'd7, 4'd15, '1);
    // Small divisor in the lowest limb only.
    queue_item(CMD_LOAD_DIVISOR, 4'd15, '0);
    queue_item(CMD_LOAD_DIVISOR, 4'd0, LW'(3));
    queue_item(CMD_DIVIDE, 4'd0, '0);
    queue_item(CMD_READ_REMAINDER, 4'd0, '0);
    queue_item(CMD_READ_QUOTIENT, 4'd15, '0);

    // Hold the sender until every result has come back.
    wait_drained();
    @(posedge clk);

    items_queued = 0;
    while (items_queued < 1200) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(2) == 0) begin
          dl = $urandom_range(LIMBS, 1);
          for (int i = 0; i < LIMBS; i++)
            queue_item(CMD_LOAD_DIVIDEND, IDX_W'(i), i < dl ? pick_limb() : '0);
        end else begin
          n = $urandom_range(4, 1);
          repeat (n) queue_item(CMD_LOAD_DIVIDEND, IDX_W'($urandom), pick_limb());
        end
        case ($urandom_range(9))
          0: for (int i = 0; i < LIMBS; i++) queue_item(CMD_LOAD_DIVISOR, IDX_W'(i), '0);
          1, 2, 3, 4: begin
            vl = $urandom_range(LIMBS, 1);
            for (int i = 0; i < LIMBS; i++)
              queue_item(CMD_LOAD_DIVISOR, IDX_W'(i), i < vl ? pick_limb() : '0);
          end
          default: begin
            n = $urandom_range(4, 1);
            repeat (n) queue_item(CMD_LOAD_DIVISOR, IDX_W'($urandom), pick_limb());
          end
        endcase
        queue_item(CMD_DIVIDE, IDX_W'($urandom), LW'($urandom));
        n = $urandom_range(10, 2);
        repeat (n)
          queue_item($urandom_range(1) ? CMD_READ_QUOTIENT : CMD_READ_REMAINDER,
                     IDX_W'($urandom), LW'($urandom));
      end else begin
        // Noise: any code, index and value.
        n = $urandom_range(6, 1);
        repeat (n) queue_item(CMD_W'($urandom_range(7)), IDX_W'($urandom), LW'($urandom));
      end
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
